// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle property, sampled on the rising clock, masked during reset.
`define NPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property that must hold in the cycle after the trigger.
`define NPS_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/nps_pkg.sv =====
`default_nettype none

package nps_pkg;

   localparam int ARR_W       = 16;
   localparam int BURST_W     = 16;
   localparam int PRIO_W      = 8;
   localparam int TIME_W      = 21;
   localparam int SUM_W       = 25;
   localparam int JOB_INDEX_W = 4;

   // Item kinds carried on req_tuser.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   // Input item payload, first field in the highest bits.
   typedef struct packed {
      logic [PRIO_W-1:0]  priority_req;
      logic [BURST_W-1:0] burst;
      logic [ARR_W-1:0]   arrival;
   } req_data_type;

   // Result item payload (tlast travels separately).
   typedef struct packed {
      logic [SUM_W-1:0]       total_response;
      logic [SUM_W-1:0]       total_turnaround;
      logic [SUM_W-1:0]       total_waiting;
      logic [TIME_W-1:0]      response_ticks;
      logic [TIME_W-1:0]      waiting_ticks;
      logic [TIME_W-1:0]      turnaround_ticks;
      logic [TIME_W-1:0]      finish_tick;
      logic [TIME_W-1:0]      start_tick;
      logic [JOB_INDEX_W-1:0] job_index;
   } rsp_data_type;

   localparam int REQ_TDATA_W = $bits(req_data_type);
   localparam int RSP_TDATA_W = $bits(rsp_data_type);

   // One row of the job table.
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  priority_req;
   } job_entry_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [SUM_W-1:0]  a;
      logic [SUM_W-1:0]  b;
   } alu_req_type;

endpackage

`default_nettype wire

// ===== rtl/core/nps_job_mem.sv =====
`default_nettype none

module nps_job_mem
   import nps_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire job_entry_type wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output job_entry_type      rd_data
);

   job_entry_type mem_ff [DEPTH];
   job_entry_type rd_data_ff;

   // Write on load, registered read every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/nps_alu.sv =====
`default_nettype none

module nps_alu
   import nps_pkg::*;
(
   input  wire alu_req_type      req,
   output logic [SUM_W-1:0]      result
);

   always_comb begin
      unique case (req.op)
         ALU_ADD: result = req.a + req.b;
         ALU_SUB: result = req.a - req.b;
         default: result = req.a + req.b;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/nonpreemptive_priority_scheduler.sv =====
`default_nettype none
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: arrival, burst, priority_req; tuser: kind
// rsp      out  rsp_tvalid/tready    tdata: job_index, times, totals; tlast: last
//
// A load item appends a job to the table. A run item takes, per dispatch, a
// scan over the job table (one memory read port), a decision, the adder steps
// for completion, turnaround, waiting and response time and the three totals
// on the shared adder, and a post of the result; each idle gap in the
// schedule costs one more scan and decision.
// Reset is synchronous and active high; it empties the job table.
// A stalled result holds the sequencer only when the next result is ready to
// post; req_tready is low for the whole of a run.

module nonpreemptive_priority_scheduler
   import nps_pkg::*;
#(
   parameter int MAX_PROCS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // req
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,  // arrival, burst, priority_req
   input  wire logic                    req_tuser,  // kind
   // rsp
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,  // job_index, start_tick,
                                                     // finish_tick, turnaround_ticks,
                                                     // waiting_ticks, response_ticks,
                                                     // total_waiting, total_turnaround,
                                                     // total_response
   output logic                         rsp_tlast   // last
);

`include "assert_macros.svh"

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      STEP_COMP,
      STEP_TAT,
      STEP_WT,
      STEP_RT,
      STEP_SUMW,
      STEP_SUMT,
      STEP_SUMR
   } step_type;

   req_data_type req_data;
   assign req_data = req_tdata;

   // Sequencer and scan state.
   state_type            state_ff,      state_in;
   step_type             step_ff,       step_in;
   logic [CNT_W-1:0]     job_count_ff,  job_count_in;
   logic [CNT_W-1:0]     done_ff,       done_in;
   logic [CNT_W-1:0]     scan_ptr_ff,   scan_ptr_in;
   logic                 rd_vld_ff,     rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff,     rd_idx_in;
   logic [MAX_PROCS-1:0] finished_ff,   finished_in;
   logic [TIME_W-1:0]    clock_now_ff,  clock_now_in;
   // Scan winners.
   logic                 best_found_ff, best_found_in;
   logic [IDX_W-1:0]     best_idx_ff,   best_idx_in;
   logic [ARR_W-1:0]     best_arr_ff,   best_arr_in;
   logic [BURST_W-1:0]   best_burst_ff, best_burst_in;
   logic [PRIO_W-1:0]    best_prio_ff,  best_prio_in;
   logic                 pend_found_ff, pend_found_in;
   logic [ARR_W-1:0]     pend_min_ff,   pend_min_in;
   // Per-dispatch figures and run totals.
   logic [TIME_W-1:0]    comp_ff,       comp_in;
   logic [TIME_W-1:0]    tat_ff,        tat_in;
   logic [TIME_W-1:0]    wt_ff,         wt_in;
   logic [TIME_W-1:0]    rt_ff,         rt_in;
   logic [SUM_W-1:0]     sumw_ff,       sumw_in;
   logic [SUM_W-1:0]     sumt_ff,       sumt_in;
   logic [SUM_W-1:0]     sumr_ff,       sumr_in;
   // Output register.
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 rsp_tlast_ff,  rsp_tlast_in;
   rsp_data_type         rsp_data_ff,   rsp_data_in;

   logic                 req_accept;
   logic                 mem_we;
   job_entry_type        mem_wdata;
   job_entry_type        mem_rdata;
   alu_req_type          alu_req;
   logic [SUM_W-1:0]     alu_res;
   logic                 last_dispatch;
   logic                 entry_ready;
   logic                 entry_wins;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign mem_wdata.arrival      = req_data.arrival;
   assign mem_wdata.burst        = req_data.burst;
   assign mem_wdata.priority_req = req_data.priority_req;

   nps_job_mem #(
      .DEPTH  (MAX_PROCS),
      .ADDR_W (IDX_W)
   ) u_job_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (job_count_ff[IDX_W-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (scan_ptr_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   nps_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   // Operand selection for the shared adder, one step per cycle.
   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = SUM_W'(clock_now_ff);
      alu_req.b  = SUM_W'(best_burst_ff);
      case (step_ff)
         STEP_COMP: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = SUM_W'(clock_now_ff);
            alu_req.b  = SUM_W'(best_burst_ff);
         end
         STEP_TAT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = SUM_W'(comp_ff);
            alu_req.b  = SUM_W'(best_arr_ff);
         end
         STEP_WT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = SUM_W'(tat_ff);
            alu_req.b  = SUM_W'(best_burst_ff);
         end
         STEP_RT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = SUM_W'(clock_now_ff);
            alu_req.b  = SUM_W'(best_arr_ff);
         end
         STEP_SUMW: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = sumw_ff;
            alu_req.b  = SUM_W'(wt_ff);
         end
         STEP_SUMT: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = sumt_ff;
            alu_req.b  = SUM_W'(tat_ff);
         end
         STEP_SUMR: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = sumr_ff;
            alu_req.b  = SUM_W'(rt_ff);
         end
         default: begin
            alu_req.op = ALU_ADD;
         end
      endcase
   end

   // Scan compare: an unfinished job that has arrived beats the current best
   // on a lower priority value, then on an earlier arrival; equal keys keep
   // the earlier load index since the scan runs upwards.
   assign entry_ready = (TIME_W'(mem_rdata.arrival) <= clock_now_ff);
   assign entry_wins  = !best_found_ff
                        || (mem_rdata.priority_req < best_prio_ff)
                        || ((mem_rdata.priority_req == best_prio_ff)
                            && (mem_rdata.arrival < best_arr_ff));

   assign last_dispatch = (done_ff == (job_count_ff - CNT_W'(1)));

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      job_count_in  = job_count_ff;
      done_in       = done_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      finished_in   = finished_ff;
      clock_now_in  = clock_now_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_prio_in  = best_prio_ff;
      pend_found_in = pend_found_ff;
      pend_min_in   = pend_min_ff;
      comp_in       = comp_ff;
      tat_in        = tat_ff;
      wt_in         = wt_ff;
      rt_in         = rt_ff;
      sumw_in       = sumw_ff;
      sumt_in       = sumt_ff;
      sumr_in       = sumr_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == KIND_LOAD) begin
                  // Append the job; drop it once the table is full.
                  if (job_count_ff < CNT_W'(MAX_PROCS)) begin
                     mem_we = 1'b1;
                     finished_in[job_count_ff[IDX_W-1:0]] = 1'b0;
                     job_count_in = job_count_ff + CNT_W'(1);
                  end
               end else if (job_count_ff != '0) begin
                  clock_now_in  = '0;
                  sumw_in       = '0;
                  sumt_in       = '0;
                  sumr_in       = '0;
                  done_in       = '0;
                  scan_ptr_in   = '0;
                  best_found_in = 1'b0;
                  pend_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle, judge each entry in the following cycle.
            if (scan_ptr_ff < job_count_ff) begin
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_ptr_ff[IDX_W-1:0];
               scan_ptr_in = scan_ptr_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
            if (rd_vld_ff && !finished_ff[rd_idx_ff]) begin
               if (entry_ready && entry_wins) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_arr_in   = mem_rdata.arrival;
                  best_burst_in = mem_rdata.burst;
                  best_prio_in  = mem_rdata.priority_req;
               end
               if (!pend_found_ff || (mem_rdata.arrival < pend_min_ff)) begin
                  pend_found_in = 1'b1;
                  pend_min_in   = mem_rdata.arrival;
               end
            end
         end

         ST_DECIDE: begin
            if (best_found_ff) begin
               finished_in[best_idx_ff] = 1'b1;
               step_in  = STEP_COMP;
               state_in = ST_CALC;
            end else begin
               // Nothing has arrived: jump to the earliest pending arrival.
               clock_now_in  = TIME_W'(pend_min_ff);
               scan_ptr_in   = '0;
               best_found_in = 1'b0;
               pend_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_CALC: begin
            case (step_ff)
               STEP_COMP: begin
                  comp_in = alu_res[TIME_W-1:0];
                  step_in = STEP_TAT;
               end
               STEP_TAT: begin
                  tat_in  = alu_res[TIME_W-1:0];
                  step_in = STEP_WT;
               end
               STEP_WT: begin
                  wt_in   = alu_res[TIME_W-1:0];
                  step_in = STEP_RT;
               end
               STEP_RT: begin
                  rt_in   = alu_res[TIME_W-1:0];
                  step_in = STEP_SUMW;
               end
               STEP_SUMW: begin
                  sumw_in = alu_res;
                  step_in = STEP_SUMT;
               end
               STEP_SUMT: begin
                  sumt_in = alu_res;
                  step_in = STEP_SUMR;
               end
               STEP_SUMR: begin
                  sumr_in  = alu_res;
                  state_in = ST_EMIT;
               end
               default: begin
                  step_in = STEP_COMP;
               end
            endcase
         end

         ST_EMIT: begin
            // Post the result once the output register is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in                = 1'b1;
               rsp_tlast_in                 = last_dispatch;
               rsp_data_in.job_index        = JOB_INDEX_W'(best_idx_ff);
               rsp_data_in.start_tick       = clock_now_ff;
               rsp_data_in.finish_tick      = comp_ff;
               rsp_data_in.turnaround_ticks = tat_ff;
               rsp_data_in.waiting_ticks    = wt_ff;
               rsp_data_in.response_ticks   = rt_ff;
               rsp_data_in.total_waiting    = last_dispatch ? sumw_ff : '0;
               rsp_data_in.total_turnaround = last_dispatch ? sumt_ff : '0;
               rsp_data_in.total_response   = last_dispatch ? sumr_ff : '0;
               clock_now_in = comp_ff;
               done_in      = done_ff + CNT_W'(1);
               if (last_dispatch) begin
                  // Run complete: empty the table.
                  finished_in  = '0;
                  job_count_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  scan_ptr_in   = '0;
                  best_found_in = 1'b0;
                  pend_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_COMP;
         job_count_ff  <= '0;
         done_ff       <= '0;
         scan_ptr_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         finished_ff   <= '0;
         clock_now_ff  <= '0;
         best_found_ff <= 1'b0;
         pend_found_ff <= 1'b0;
         sumw_ff       <= '0;
         sumt_ff       <= '0;
         sumr_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         job_count_ff  <= job_count_in;
         done_ff       <= done_in;
         scan_ptr_ff   <= scan_ptr_in;
         rd_vld_ff     <= rd_vld_in;
         finished_ff   <= finished_in;
         clock_now_ff  <= clock_now_in;
         best_found_ff <= best_found_in;
         pend_found_ff <= pend_found_in;
         sumw_ff       <= sumw_in;
         sumt_ff       <= sumt_in;
         sumr_ff       <= sumr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_tlast_ff  <= rsp_tlast_in;
      end
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_prio_ff  <= best_prio_in;
      pend_min_ff   <= pend_min_in;
      comp_ff       <= comp_in;
      tat_ff        <= tat_in;
      wt_ff         <= wt_in;
      rt_ff         <= rt_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = rsp_data_ff;

   `NPS_ASSERT(a_count_bound, job_count_ff <= CNT_W'(MAX_PROCS), "job count beyond table")
   `NPS_ASSERT(a_run_progress, (state_ff != ST_IDLE) |-> (done_ff < job_count_ff),
      "dispatch count overran")
   `NPS_ASSERT(a_idle_empty, $rose(req_tready) |-> (job_count_ff == '0),
      "table not cleared after run")
   `NPS_ASSERT_NEXT(a_pick_marked, (state_ff == ST_DECIDE) && best_found_ff,
      finished_ff[best_idx_ff], "dispatched job not marked")
   `NPS_ASSERT(a_wait_eq_resp,
      rsp_tvalid_ff |-> (rsp_data_ff.waiting_ticks == rsp_data_ff.response_ticks),
      "waiting differs from response")
   `NPS_ASSERT(a_totals_last, (rsp_tvalid_ff && !rsp_tlast_ff) |->
      ((rsp_data_ff.total_waiting == '0) && (rsp_data_ff.total_response == '0)),
      "totals on a non-final result")

endmodule

`default_nettype wire
